// ===== design/assert_macros.svh =====
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ===== design/cobm_pkg.sv =====
package cobm_pkg;

    localparam int DefaultNumOsc = 16;
    localparam int DataW = 24;
    localparam int FreqW = 23;
    localparam int GainW = 24;
    localparam int CfgW = 24;
    localparam int CfgIdxW = 2;

    localparam logic [CfgIdxW-1:0] CfgMixMode = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgMixScale = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgActiveCount = 2'd2;

    localparam logic OpTick = 1'b0;
    localparam logic OpLoad = 1'b1;

    localparam logic [GainW-1:0] UnityGain = 24'd8388608;

    typedef struct packed {
        logic                    operation;
        logic [3:0]              osc_index;
        logic signed [DataW-1:0] cos_value;
        logic signed [DataW-1:0] sin_value;
        logic [FreqW-1:0]        freq_coef;
        logic [GainW-1:0]        decay_gain;
    } request_t;

    typedef struct packed {
        logic signed [DataW-1:0] sample;
        logic                    saturated;
    } result_t;

    // operand pair for the serial multiplier, a wide enough for the full sum
    typedef struct packed {
        logic                    start;
        logic signed [DataW+8:0] a;
        logic [GainW-1:0]        b;
    } mul_req_t;

    function automatic logic signed [DataW-1:0] sat24(input logic signed [63:0] v);
        if (v > 64'sd8388607)
            sat24 = 24'sh7FFFFF;
        else if (v < -64'sd8388608)
            sat24 = -24'sh800000;
        else
            sat24 = v[DataW-1:0];
    endfunction

    function automatic logic clips24(input logic signed [63:0] v);
        clips24 = (v > 64'sd8388607) || (v < -64'sd8388608);
    endfunction

    // round half up then shift right
    function automatic logic signed [63:0] rshr(input logic signed [63:0] v, input int k);
        logic signed [63:0] t;
        t = v + (64'sd1 <<< (k - 1));
        rshr = t >>> k;
    endfunction

endpackage

// ===== design/coupled_oscillator_bank_mixer_top.sv =====
// Bank of coupled-form sine oscillators. A load request is taken while idle
// and busy stays low; a tick request advances the active oscillators and returns
// one sample on result/result_valid for a single cycle, which the receiver
// must take. Every product runs through one 2-bit-per-cycle multiplier of
// 12 steps. An oscillator needs three products in sum mode and four in
// product mode; sum mode adds one scale product at the end. result_valid
// rises in the same cycle that busy falls.
module coupled_oscillator_bank_mixer_top
    import cobm_pkg::*;
#(
    parameter int NumOsc = DefaultNumOsc
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  request_t          request,
    output logic              result_valid,
    output result_t           result,
    input  logic              cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgW-1:0]   cfg_data
);
    localparam int IdxW = (NumOsc > 1) ? $clog2(NumOsc) : 1;
    localparam int CntW = $clog2(NumOsc + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_READ  = 10'b0000000010,
        S_WAIT  = 10'b0000000100,
        S_MC    = 10'b0000001000,
        S_MS    = 10'b0000010000,
        S_MACC  = 10'b0000100000,
        S_MDEC  = 10'b0001000000,
        S_NEXT  = 10'b0010000000,
        S_SCALE = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic mix_mode_reg;
    logic [CfgW-1:0] mix_scale_reg;
    logic [4:0] active_count_reg;
    logic [NumOsc-1:0] valid_reg;
    logic [IdxW-1:0] idx_reg, idx_next;
    logic [CntW-1:0] n_eff;
    logic signed [DataW-1:0] c_reg, s_reg;
    logic signed [DataW+8:0] acc_reg;
    logic clip_reg;
    logic signed [DataW-1:0] sample_reg;
    logic out_valid_reg;
    logic [FreqW-1:0] f_q;
    logic [GainW-1:0] g_q;
    logic [DataW-1:0] c_q, s_q;
    logic we;
    logic [IdxW-1:0] waddr;
    logic [DataW-1:0] c_w, s_w;
    logic [FreqW-1:0] f_w;
    logic [GainW-1:0] g_w;
    logic wr_cs;
    mul_req_t mreq;
    logic mdone;
    logic signed [63:0] mprod;
    logic signed [63:0] t;
    logic rd_valid;
    logic signed [DataW-1:0] c_rd, s_rd;
    logic [FreqW-1:0] f_rd;
    logic [GainW-1:0] g_rd;
    logic load_ok;

    always_comb
    begin
        if (active_count_reg == 5'd0)
            n_eff = CntW'(1);
        else if (32'(active_count_reg) > NumOsc)
            n_eff = CntW'(NumOsc);
        else
            n_eff = CntW'(active_count_reg);
    end

    assign load_ok = (32'(request.osc_index) < NumOsc);

    cobm_ram #(.Width(DataW), .Depth(NumOsc)) u_cos (.clk, .we(we || wr_cs),
        .waddr, .wdata(c_w), .raddr(idx_reg), .rdata(c_q));
    cobm_ram #(.Width(DataW), .Depth(NumOsc)) u_sin (.clk, .we(we || wr_cs),
        .waddr, .wdata(s_w), .raddr(idx_reg), .rdata(s_q));
    cobm_ram #(.Width(FreqW), .Depth(NumOsc)) u_freq (.clk, .we,
        .waddr, .wdata(f_w), .raddr(idx_reg), .rdata(f_q));
    cobm_ram #(.Width(GainW), .Depth(NumOsc)) u_dec (.clk, .we,
        .waddr, .wdata(g_w), .raddr(idx_reg), .rdata(g_q));

    cobm_mul u_mul (.clk, .rst_n, .req(mreq), .done(mdone), .prod(mprod));

    assign rd_valid = valid_reg[idx_reg];
    assign c_rd = rd_valid ? signed'(c_q) : '0;
    assign s_rd = rd_valid ? signed'(s_q) : '0;
    assign f_rd = rd_valid ? f_q : '0;
    assign g_rd = rd_valid ? g_q : UnityGain;

    logic load_fire;
    assign load_fire = start && !busy && request.operation == OpLoad && load_ok;
    assign we = load_fire || (state_reg == S_MDEC && mdone && !rd_valid);
    assign waddr = load_fire ? IdxW'(request.osc_index) : idx_reg;
    assign f_w = load_fire ? request.freq_coef : '0;
    assign g_w = load_fire ? request.decay_gain : UnityGain;

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        mreq = '0;
        wr_cs = 1'b0;
        t = '0;
        c_w = load_fire ? request.cos_value : c_reg;
        s_w = load_fire ? request.sin_value : s_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && request.operation == OpTick)
                begin
                    idx_next = '0;
                    state_next = S_READ;
                end
            end
            S_READ: state_next = S_WAIT;
            S_WAIT:
            begin
                mreq.start = 1'b1;
                mreq.a = 33'(s_rd);
                mreq.b = 24'(f_rd);
                state_next = S_MC;
            end
            S_MC:
            begin
                if (mdone)
                begin
                    mreq.start = 1'b1;
                    t = 64'(c_reg) + rshr(mprod, 22);
                    mreq.a = 33'(sat24(t));
                    mreq.b = 24'(f_rd);
                    state_next = S_MS;
                end
            end
            S_MS:
            begin
                if (mdone)
                begin
                    t = 64'(s_reg) - rshr(mprod, 22);
                    if (mix_mode_reg)
                    begin
                        mreq.start = 1'b1;
                        mreq.a = acc_reg;
                        mreq.b = 24'(sat24(t));
                        state_next = S_MACC;
                    end
                    else
                    begin
                        mreq.start = 1'b1;
                        mreq.a = 33'(sat24(t));
                        mreq.b = g_rd;
                        state_next = S_MDEC;
                    end
                end
            end
            S_MACC:
            begin
                if (mdone)
                begin
                    mreq.start = 1'b1;
                    mreq.a = 33'(s_reg);
                    mreq.b = g_rd;
                    state_next = S_MDEC;
                end
            end
            S_MDEC:
            begin
                if (mdone)
                begin
                    wr_cs = rd_valid;
                    s_w = sat24(rshr(mprod, 23));
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (32'(idx_reg) + 1 >= 32'(n_eff))
                begin
                    if (mix_mode_reg)
                        state_next = S_DONE;
                    else
                    begin
                        mreq.start = 1'b1;
                        mreq.a = acc_reg;
                        mreq.b = mix_scale_reg;
                        state_next = S_SCALE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + IdxW'(1);
                    state_next = S_READ;
                end
            end
            S_SCALE: if (mdone) state_next = S_DONE;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg <= '0;
            mix_mode_reg <= 1'b0;
            mix_scale_reg <= UnityGain;
            active_count_reg <= 5'd16;
            valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            out_valid_reg <= (state_reg == S_DONE);
            if (load_fire)
                valid_reg[IdxW'(request.osc_index)] <= 1'b1;
            if (state_reg == S_MDEC && mdone)
                valid_reg[idx_reg] <= 1'b1;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CfgMixMode: mix_mode_reg <= cfg_data[0];
                    CfgMixScale: mix_scale_reg <= cfg_data;
                    CfgActiveCount: active_count_reg <= cfg_data[4:0];
                    default: ;
                endcase
            end
        end
    end

    // signed sign correction for product mode: b is treated unsigned by the
    // multiplier, so subtract a<<24 when the sine operand is negative
    logic signed [63:0] pm_prod;
    assign pm_prod = mprod - ((s_reg < 0) ? (64'(acc_reg) <<< 24) : 64'sd0);

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                acc_reg <= mix_mode_reg ? 33'sd524288 : '0;
                clip_reg <= 1'b0;
            end
            S_WAIT:
            begin
                c_reg <= c_rd;
                s_reg <= s_rd;
            end
            S_MC:
                if (mdone)
                    c_reg <= sat24(64'(c_reg) + rshr(mprod, 22));
            S_MS:
                if (mdone)
                begin
                    s_reg <= sat24(64'(s_reg) - rshr(mprod, 22));
                    if (!mix_mode_reg)
                        acc_reg <= acc_reg + 33'(sat24(64'(s_reg) - rshr(mprod, 22)));
                end
            S_MACC:
                if (mdone)
                begin
                    acc_reg <= 33'(sat24(rshr(pm_prod, 19)));
                    if (clips24(rshr(pm_prod, 19)))
                        clip_reg <= 1'b1;
                end
            S_SCALE:
                if (mdone)
                begin
                    sample_reg <= sat24(rshr(mprod, 23));
                    clip_reg <= clips24(rshr(mprod, 23));
                end
            S_DONE:
                if (mix_mode_reg)
                    sample_reg <= acc_reg[DataW-1:0];
            default: ;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign result.sample = sample_reg;
    assign result.saturated = clip_reg;
endmodule

// ===== design/cobm_ram.sv =====
module cobm_ram #(
    parameter int Width = 24,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ===== design/cobm_mul.sv =====
// shift-add multiplier, two bits of the unsigned operand per cycle
module cobm_mul
    import cobm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mul_req_t                req,
    output logic                    done,
    output logic signed [63:0]      prod
);
    localparam int Steps = GainW / 2;

    logic signed [63:0] acc_reg, acc_next;
    logic signed [63:0] mcand_reg, mcand_next;
    logic [GainW-1:0]   mplier_reg, mplier_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic signed [63:0] part;

    always_comb
    begin
        acc_next = acc_reg;
        mcand_next = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        part = '0;
        if (req.start)
        begin
            acc_next = '0;
            mcand_next = 64'(req.a);
            mplier_next = req.b;
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                part = part + mcand_reg;
            if (mplier_reg[1])
                part = part + (mcand_reg <<< 1);
            acc_next = acc_reg + part;
            mcand_next = mcand_reg <<< 2;
            mplier_next = mplier_reg >> 2;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(Steps - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mcand_reg <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule

// ===== design/cobm_checker.sv =====
`include "assert_macros.svh"

module cobm_checker
    import cobm_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input request_t request,
    input logic     result_valid
);
    `ASSERT_NEXT(a_tick_busy, clk, rst_n, start && !busy && request.operation == OpTick, busy)
    `ASSERT_NEXT(a_load_idle, clk, rst_n, start && !busy && request.operation == OpLoad, !busy)
    `ASSERT_IMPLIES(a_res_idle, clk, rst_n, result_valid, !busy)
    `ASSERT_NEXT(a_res_single, clk, rst_n, result_valid, !result_valid)
endmodule

bind coupled_oscillator_bank_mixer_top cobm_checker u_checker (
    .clk, .rst_n, .start, .busy, .request, .result_valid);
